// File: sv/hspe_pkg.sv
// Shared types, constants and the evaluation microprogram for the Hermite spline evaluator.
package hspe_pkg;

	// Input word: one load or evaluate item
	typedef struct packed {
		logic               kind;
		logic [5:0]         point_index;
		logic [15:0]        t_param;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} in_word_t;

	// Output word: one evaluated point
	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               degenerate;
		logic               saturated;
	} out_word_t;

	// One control point table entry
	typedef struct packed {
		logic [15:0]        t;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
	} entry_t;

	localparam int ENTRY_W  = $bits(entry_t);
	localparam int ACC_W    = 128;
	localparam int DIV_BITS = 104;
	localparam int MUL_BITS = 17;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	localparam logic [15:0] ONE_Q15 = 16'd32768;

	// Datapath micro-operations
	typedef enum logic [2:0] {
		OP_NOP    = 3'd0,
		OP_LOAD   = 3'd1,
		OP_MUL    = 3'd2,
		OP_SAVE   = 3'd3,
		OP_XCHG   = 3'd4,
		OP_ADDSAV = 3'd5,
		OP_SETD   = 3'd6,
		OP_DIV    = 3'd7
	} op_t;

	// Operand sources (load value or multiply addend)
	typedef enum logic [3:0] {
		SRC_ZERO = 4'd0,
		SRC_H    = 4'd1,
		SRC_V10  = 4'd2,
		SRC_K2   = 4'd3,
		SRC_NV   = 4'd4,
		SRC_K3   = 4'd5,
		SRC_V0   = 4'd6,
		SRC_P0S  = 4'd7,
		SRC_SAV  = 4'd8
	} src_t;

	typedef struct packed {
		op_t  op;
		src_t src;
		logic m_tx;
	} uop_t;

	// Output register source
	typedef enum logic [1:0] {
		OSEL_CALC = 2'd0,
		OSEL_E0   = 2'd1,
		OSEL_LAST = 2'd2
	} osel_t;

	// Controller to datapath
	typedef struct packed {
		logic       we;
		logic       cap_t;
		logic       cap_e0;
		logic       cap_e1;
		logic       run;
		uop_t       uop;
		logic [1:0] coord;
		logic       out_load;
		osel_t      out_sel;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic busy;
		logic t_over;
		logic t_gt_rd;
		logic h_zero;
	} sts_t;

	localparam logic [4:0] PC_BODY = 5'd4;
	localparam logic [4:0] PC_LAST = 5'd22;

	function automatic uop_t mk_uop(input op_t o, input src_t s, input logic m);
		uop_t u;
		u.op   = o;
		u.src  = s;
		u.m_tx = m;
		return u;
	endfunction

	// Prelude builds h^3 once per segment; the body runs once per coordinate.
	// N = tx^2*(X*tx + h*Y) + h^3*(v0*tx + p0<<15)
	function automatic uop_t prog_uop(input logic [4:0] pc);
		uop_t u;
		case (pc)
			5'd0:    u = mk_uop(OP_LOAD,   SRC_H,    1'b0);
			5'd1:    u = mk_uop(OP_MUL,    SRC_ZERO, 1'b0);
			5'd2:    u = mk_uop(OP_MUL,    SRC_ZERO, 1'b0);
			5'd3:    u = mk_uop(OP_SETD,   SRC_ZERO, 1'b0);
			5'd4:    u = mk_uop(OP_LOAD,   SRC_V10,  1'b0);
			5'd5:    u = mk_uop(OP_MUL,    SRC_K2,   1'b0);
			5'd6:    u = mk_uop(OP_SAVE,   SRC_ZERO, 1'b0);
			5'd7:    u = mk_uop(OP_LOAD,   SRC_NV,   1'b0);
			5'd8:    u = mk_uop(OP_MUL,    SRC_K3,   1'b0);
			5'd9:    u = mk_uop(OP_MUL,    SRC_ZERO, 1'b0);
			5'd10:   u = mk_uop(OP_XCHG,   SRC_ZERO, 1'b0);
			5'd11:   u = mk_uop(OP_MUL,    SRC_SAV,  1'b1);
			5'd12:   u = mk_uop(OP_MUL,    SRC_ZERO, 1'b1);
			5'd13:   u = mk_uop(OP_MUL,    SRC_ZERO, 1'b1);
			5'd14:   u = mk_uop(OP_SAVE,   SRC_ZERO, 1'b0);
			5'd15:   u = mk_uop(OP_LOAD,   SRC_V0,   1'b0);
			5'd16:   u = mk_uop(OP_MUL,    SRC_P0S,  1'b1);
			5'd17:   u = mk_uop(OP_MUL,    SRC_ZERO, 1'b0);
			5'd18:   u = mk_uop(OP_MUL,    SRC_ZERO, 1'b0);
			5'd19:   u = mk_uop(OP_MUL,    SRC_ZERO, 1'b0);
			5'd20:   u = mk_uop(OP_ADDSAV, SRC_ZERO, 1'b0);
			5'd21:   u = mk_uop(OP_DIV,    SRC_ZERO, 1'b0);
			default: u = mk_uop(OP_NOP,    SRC_ZERO, 1'b0);
		endcase
		return u;
	endfunction

endpackage

// File: sv/hspe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hspe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/hspe_datapath.sv
// Datapath: point table, shift-add multiplier, restoring divider and output register.
module hspe_datapath #(
	parameter int MAX_POINTS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hspe_pkg::in_word_t   in_data,
	input  hspe_pkg::cmd_t       cmd,
	input  logic [$clog2(MAX_POINTS)-1:0] raddr,
	output hspe_pkg::sts_t       sts,
	output hspe_pkg::out_word_t  out_data
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int AC = hspe_pkg::ACC_W;

	hspe_pkg::entry_t wentry;
	logic [hspe_pkg::ENTRY_W-1:0] rdata;
	hspe_pkg::entry_t rentry;

	// Point table
	always_comb begin
		wentry.t  = in_data.t_param;
		wentry.px = in_data.pos_x;
		wentry.py = in_data.pos_y;
		wentry.pz = in_data.pos_z;
		wentry.vx = in_data.vel_x;
		wentry.vy = in_data.vel_y;
		wentry.vz = in_data.vel_z;
	end

	hspe_ram #(
		.WIDTH(hspe_pkg::ENTRY_W),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk  (clk),
		.we   (cmd.we),
		.waddr(AW'(in_data.point_index)),
		.wdata(wentry),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rentry = hspe_pkg::entry_t'(rdata);

	// Captured item and segment endpoints
	logic [15:0]      t_q;
	hspe_pkg::entry_t e0_q, e1_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_t) begin
			t_q <= in_data.t_param;
		end
		if (cmd.cap_e0) begin
			e0_q <= rentry;
		end
		if (cmd.cap_e1) begin
			e1_q <= rentry;
		end
	end

	logic signed [16:0] h_s, tx_s;
	assign h_s  = $signed({1'b0, e1_q.t}) - $signed({1'b0, e0_q.t});
	assign tx_s = $signed({1'b0, t_q}) - $signed({1'b0, e0_q.t});

	// Per-coordinate operands
	logic signed [31:0] p0, p1, v0, v1;
	always_comb begin
		case (cmd.coord)
			2'd0: begin
				p0 = e0_q.px; p1 = e1_q.px; v0 = e0_q.vx; v1 = e1_q.vx;
			end
			2'd1: begin
				p0 = e0_q.py; p1 = e1_q.py; v0 = e0_q.vy; v1 = e1_q.vy;
			end
			default: begin
				p0 = e0_q.pz; p1 = e1_q.pz; v0 = e0_q.vz; v1 = e1_q.vz;
			end
		endcase
	end

	logic signed [AC-1:0] p0w, p1w, v0w, v1w, dpw, hw;
	logic signed [AC-1:0] acc_q, sav_q, add_q, prod_q, src_val;
	assign p0w = AC'(p0);
	assign p1w = AC'(p1);
	assign v0w = AC'(v0);
	assign v1w = AC'(v1);
	assign hw  = AC'(h_s);
	assign dpw = p1w - p0w;

	always_comb begin
		case (cmd.uop.src)
			hspe_pkg::SRC_H:   src_val = hw;
			hspe_pkg::SRC_V10: src_val = v1w + v0w;
			hspe_pkg::SRC_K2:  src_val = -(dpw <<< 16);
			hspe_pkg::SRC_NV:  src_val = -(v1w + (v0w <<< 1));
			hspe_pkg::SRC_K3:  src_val = (dpw + (dpw <<< 1)) <<< 15;
			hspe_pkg::SRC_V0:  src_val = v0w;
			hspe_pkg::SRC_P0S: src_val = p0w <<< 15;
			hspe_pkg::SRC_SAV: src_val = sav_q;
			default:           src_val = '0;
		endcase
	end

	// Multiplier: one bit of the 17-bit signed factor per cycle, MSB first
	logic signed [16:0]   mulm_q;
	logic [4:0]           mcnt_q;
	logic signed [AC-1:0] mterm, prod_n;
	always_comb begin
		if (!mulm_q[mcnt_q]) begin
			mterm = '0;
		end else if (mcnt_q == 5'(hspe_pkg::MUL_BITS - 1)) begin
			mterm = -acc_q;
		end else begin
			mterm = acc_q;
		end
		prod_n = (prod_q <<< 1) + mterm;
	end

	// Divider: |N| / d, one quotient bit per cycle
	logic [AC-1:0]  acc_abs;
	logic [63:0]    d_q, rem_q;
	logic           dneg_q, nneg_q, ovf_q;
	logic [hspe_pkg::DIV_BITS-1:0] nmag_q;
	logic [6:0]     dcnt_q;
	logic [32:0]    quo_q;
	logic [64:0]    r2;
	logic           ge;
	assign acc_abs = acc_q[AC-1] ? AC'(-acc_q) : acc_q;
	assign r2      = {rem_q, nmag_q[dcnt_q]};
	assign ge      = r2 >= {1'b0, d_q};

	// Round to nearest, ties away from zero, then saturate
	logic        rup, rneg, rsat;
	logic [33:0] qr;
	logic [31:0] rval;
	always_comb begin
		rup  = rem_q >= (d_q - rem_q);
		qr   = {1'b0, quo_q} + 34'(rup);
		rneg = nneg_q ^ dneg_q;
		if (rneg) begin
			rsat = ovf_q || (qr > 34'h080000000);
			rval = rsat ? 32'h80000000 : (~qr[31:0] + 32'd1);
		end else begin
			rsat = ovf_q || (qr > 34'h07FFFFFFF);
			rval = rsat ? 32'h7FFFFFFF : qr[31:0];
		end
	end

	// Sequencing control
	logic busy_q, mode_div_q, fin_q, sat_q;
	logic start;
	assign start = cmd.run && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			mode_div_q <= 1'b0;
			fin_q      <= 1'b0;
		end else if (start) begin
			if (cmd.uop.op == hspe_pkg::OP_MUL) begin
				busy_q     <= 1'b1;
				mode_div_q <= 1'b0;
				fin_q      <= 1'b0;
			end else if (cmd.uop.op == hspe_pkg::OP_DIV) begin
				busy_q     <= 1'b1;
				mode_div_q <= 1'b1;
				fin_q      <= 1'b0;
			end
		end else if (busy_q) begin
			if (!mode_div_q) begin
				if (mcnt_q == 5'd0) begin
					busy_q <= 1'b0;
				end
			end else if (fin_q) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b0;
			end else if (dcnt_q == 7'd0) begin
				fin_q <= 1'b1;
			end
		end
	end

	// Arithmetic registers
	logic signed [31:0] res_q [3];
	always_ff @(posedge clk) begin
		if (cmd.cap_e0) begin
			sat_q <= 1'b0;
		end
		if (start) begin
			case (cmd.uop.op)
				hspe_pkg::OP_LOAD: acc_q <= src_val;
				hspe_pkg::OP_MUL: begin
					mulm_q <= cmd.uop.m_tx ? tx_s : h_s;
					add_q  <= src_val;
					prod_q <= '0;
					mcnt_q <= 5'(hspe_pkg::MUL_BITS - 1);
				end
				hspe_pkg::OP_SAVE: sav_q <= acc_q;
				hspe_pkg::OP_XCHG: begin
					acc_q <= sav_q;
					sav_q <= acc_q;
				end
				hspe_pkg::OP_ADDSAV: acc_q <= acc_q + sav_q;
				hspe_pkg::OP_SETD: begin
					d_q    <= {acc_abs[48:0], 15'd0};
					dneg_q <= acc_q[AC-1];
				end
				hspe_pkg::OP_DIV: begin
					nneg_q <= acc_q[AC-1];
					nmag_q <= acc_abs[hspe_pkg::DIV_BITS-1:0];
					rem_q  <= '0;
					quo_q  <= '0;
					ovf_q  <= 1'b0;
					dcnt_q <= 7'(hspe_pkg::DIV_BITS - 1);
				end
				default: ;
			endcase
		end else if (busy_q) begin
			if (!mode_div_q) begin
				prod_q <= prod_n;
				if (mcnt_q == 5'd0) begin
					acc_q <= prod_n + add_q;
				end else begin
					mcnt_q <= mcnt_q - 5'd1;
				end
			end else if (fin_q) begin
				res_q[cmd.coord] <= rval;
				if (rsat) begin
					sat_q <= 1'b1;
				end
			end else begin
				rem_q <= ge ? r2[63:0] - d_q : r2[63:0];
				quo_q <= {quo_q[31:0], ge};
				ovf_q <= ovf_q | quo_q[32];
				if (dcnt_q != 7'd0) begin
					dcnt_q <= dcnt_q - 7'd1;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_sel)
				hspe_pkg::OSEL_CALC: begin
					out_data.out_x      <= res_q[0];
					out_data.out_y      <= res_q[1];
					out_data.out_z      <= res_q[2];
					out_data.degenerate <= 1'b0;
					out_data.saturated  <= sat_q;
				end
				hspe_pkg::OSEL_E0: begin
					out_data.out_x      <= e0_q.px;
					out_data.out_y      <= e0_q.py;
					out_data.out_z      <= e0_q.pz;
					out_data.degenerate <= 1'b1;
					out_data.saturated  <= 1'b0;
				end
				default: begin
					out_data.out_x      <= e1_q.px;
					out_data.out_y      <= e1_q.py;
					out_data.out_z      <= e1_q.pz;
					out_data.degenerate <= 1'b0;
					out_data.saturated  <= 1'b0;
				end
			endcase
		end
	end

	// Status
	assign sts.busy    = busy_q;
	assign sts.t_over  = t_q > hspe_pkg::ONE_Q15;
	assign sts.t_gt_rd = t_q > rentry.t;
	assign sts.h_zero  = e1_q.t == e0_q.t;

endmodule

// File: sv/hspe_ctrl.sv
// Controller: handshakes, point count register, segment search and microprogram sequencing.
module hspe_ctrl #(
	parameter int MAX_POINTS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_kind,
	input  logic [5:0]           in_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 cfg_we,
	input  logic [6:0]           cfg_data,
	input  hspe_pkg::sts_t       sts,
	output hspe_pkg::cmd_t       cmd,
	output logic [$clog2(MAX_POINTS)-1:0] raddr
);

	localparam int AW = $clog2(MAX_POINTS);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_CHK   = 12'b000000000010,
		S_LCAP  = 12'b000000000100,
		S_SRD   = 12'b000000001000,
		S_SCMP  = 12'b000000010000,
		S_F0    = 12'b000000100000,
		S_F1    = 12'b000001000000,
		S_F2    = 12'b000010000000,
		S_HCHK  = 12'b000100000000,
		S_ISSUE = 12'b001000000000,
		S_WAIT  = 12'b010000000000,
		S_OUT   = 12'b100000000000
	} state_t;

	state_t        state_q, state_n;
	logic [6:0]    point_count_q;
	logic [AW-1:0] seg_q;
	logic [4:0]    pc_q;
	logic [1:0]    coord_q;
	logic [AW:0]   n_use;
	logic [AW-1:0] last_idx;
	logic          in_acc, seg_more, idx_ok;

	// Point count, clamped to the table
	always_comb begin
		if (int'(point_count_q) < 2) begin
			n_use = (AW+1)'(2);
		end else if (int'(point_count_q) > MAX_POINTS) begin
			n_use = (AW+1)'(MAX_POINTS);
		end else begin
			n_use = (AW+1)'(point_count_q);
		end
	end
	assign last_idx = AW'(n_use - (AW+1)'(1));
	assign seg_more = ({1'b0, seg_q} + (AW+1)'(2)) < n_use;
	assign idx_ok   = int'(in_index) < MAX_POINTS;

	assign in_ready = state_q == S_IDLE;
	assign in_acc   = in_valid && in_ready;

	// Table read address
	always_comb begin
		unique case (state_q)
			S_CHK:         raddr = last_idx;
			S_SRD, S_F1:   raddr = seg_q + AW'(1);
			default:       raddr = seg_q;
		endcase
	end

	// Commands and next state
	always_comb begin
		state_n      = state_q;
		cmd.we       = in_acc && (in_kind == hspe_pkg::KIND_LOAD) && idx_ok;
		cmd.cap_t    = in_acc && (in_kind == hspe_pkg::KIND_EVAL);
		cmd.cap_e0   = 1'b0;
		cmd.cap_e1   = 1'b0;
		cmd.run      = 1'b0;
		cmd.uop      = hspe_pkg::prog_uop(pc_q);
		cmd.coord    = coord_q;
		cmd.out_load = 1'b0;
		cmd.out_sel  = hspe_pkg::OSEL_CALC;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && in_kind == hspe_pkg::KIND_EVAL) begin
					state_n = S_CHK;
				end
			end
			S_CHK:  state_n = sts.t_over ? S_LCAP : S_SRD;
			S_LCAP: begin
				cmd.cap_e1  = 1'b1;
				state_n     = S_OUT;
			end
			S_SRD:  state_n = seg_more ? S_SCMP : S_F0;
			S_SCMP: state_n = sts.t_gt_rd ? S_SRD : S_F0;
			S_F0:   state_n = S_F1;
			S_F1: begin
				cmd.cap_e0 = 1'b1;
				state_n    = S_F2;
			end
			S_F2: begin
				cmd.cap_e1 = 1'b1;
				state_n    = S_HCHK;
			end
			S_HCHK: state_n = sts.h_zero ? S_OUT : S_ISSUE;
			S_ISSUE: begin
				cmd.run = 1'b1;
				state_n = S_WAIT;
			end
			S_WAIT: begin
				if (!sts.busy) begin
					if (pc_q == hspe_pkg::PC_LAST && coord_q == 2'd2) begin
						state_n = S_OUT;
					end else begin
						state_n = S_ISSUE;
					end
				end
			end
			S_OUT: begin
				cmd.out_sel = sts.t_over ? hspe_pkg::OSEL_LAST :
				              (sts.h_zero ? hspe_pkg::OSEL_E0 : hspe_pkg::OSEL_CALC);
				if (!out_valid || out_ready) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			point_count_q <= 7'd2;
			seg_q         <= '0;
			pc_q          <= '0;
			coord_q       <= '0;
			out_valid     <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				point_count_q <= cfg_data;
			end
			if (state_q == S_CHK) begin
				seg_q <= '0;
			end else if (state_q == S_SCMP && sts.t_gt_rd) begin
				seg_q <= seg_q + AW'(1);
			end
			if (state_q == S_HCHK) begin
				pc_q    <= '0;
				coord_q <= '0;
			end else if (state_q == S_WAIT && !sts.busy) begin
				if (pc_q == hspe_pkg::PC_LAST) begin
					pc_q    <= hspe_pkg::PC_BODY;
					coord_q <= coord_q + 2'd1;
				end else begin
					pc_q <= pc_q + 5'd1;
				end
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Table is written only between evaluations
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.we |-> state_q == S_IDLE)
		else $error("table write outside idle");

	// No micro-op issued while the datapath is still working
	a_run_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run |-> !sts.busy)
		else $error("micro-op issued while busy");

	// The final micro-op of the third coordinate leads to the output state
	a_prog_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT && !sts.busy && pc_q == hspe_pkg::PC_LAST && coord_q == 2'd2)
		|=> state_q == S_OUT)
		else $error("program end did not reach output");

	// Loading the output raises valid and frees the input side
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid && state_q == S_IDLE)
		else $error("output load did not complete");

endmodule

// File: sv/hermite_spline_point_eval_unit.sv
// Top level: Hermite spline point evaluator, controller plus datapath.
// Load word: accepted in idle, written to the table in the same cycle if its index is within the table.
// Evaluate word: t above 1.0 returns the last point; otherwise the search reads and compares one
// segment at a time, then the arithmetic runs on the bit-serial 17-bit multiplier and
// the 104-step restoring divider, once per coordinate.
// One evaluation at a time; reset clears control state, the point table is not cleared.
module hermite_spline_point_eval_unit #(
	parameter int MAX_POINTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hspe_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hspe_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_data
);

	localparam int AW = $clog2(MAX_POINTS);

	hspe_pkg::cmd_t cmd;
	hspe_pkg::sts_t sts;
	logic [AW-1:0]  raddr;

	hspe_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_kind  (in_data.kind),
		.in_index (in_data.point_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.sts      (sts),
		.cmd      (cmd),
		.raddr    (raddr)
	);

	hspe_datapath #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.cmd     (cmd),
		.raddr   (raddr),
		.sts     (sts),
		.out_data(out_data)
	);

endmodule
